FILE: src/chc_pkg.sv
// Shared types, widths and constants for the compass calibration and heading block.
// Depends on nothing; every other file of the block imports it.
package chc_pkg;

	// Widths of the sample path
	localparam int SAMPLE_BITS     = 16;
	localparam int ANGLE_FRAC_BITS = 4;
	localparam int ATAN_ITERATIONS = 16;
	localparam int NUM_AXES        = 3;
	localparam int CORR_W          = SAMPLE_BITS + 1;
	localparam int HEAD_W          = 9 + ANGLE_FRAC_BITS;
	localparam int CAL_W           = 16;

	// CORDIC arithmetic: degrees in signed Q.24
	localparam int ACC_FRAC  = 24;
	localparam int TAB_LEN   = 24;
	localparam int TAB_IW    = $clog2(TAB_LEN);
	localparam int ITERS     = (ATAN_ITERATIONS > TAB_LEN) ? TAB_LEN : ATAN_ITERATIONS;
	localparam int ITER_W    = $clog2(ITERS);
	localparam int CW        = CORR_W + ACC_FRAC + 3;
	localparam int ZW        = ACC_FRAC + 10;
	localparam int RND_SH    = ACC_FRAC - ANGLE_FRAC_BITS;

	// Heading limits
	localparam int HEAD_MAX  = 180 << ANGLE_FRAC_BITS;

	// Configuration port
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] ADDR_CAL_COUNT = '0;
	localparam logic [CAL_W-1:0]  CAL_COUNT_RST  = CAL_W'(500);

	// Item codes
	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_CAL     = 1'b1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [CORR_W-1:0]      corr_t;
	typedef logic signed [HEAD_W-1:0]      head_t;
	typedef logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] axis_vec_t;

	// atan(2^-i) in degrees, Q.24
	localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
		32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
		32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
		32'd234684,    32'd117342,    32'd58671,     32'd29335,
		32'd14668,     32'd7334,      32'd3667,      32'd1833,
		32'd917,       32'd458,       32'd229,       32'd115
	};

endpackage

FILE: src/chc_ifs.sv
// Valid/ready channel interfaces for sample words and result words.
// Depends on chc_pkg for the payload types.
interface chc_sample_if;
	import chc_pkg::*;
	logic    valid;
	logic    ready;
	logic    op;
	sample_t raw_x;
	sample_t raw_y;
	sample_t raw_z;
	modport source (output valid, op, raw_x, raw_y, raw_z, input ready);
	modport sink   (input valid, op, raw_x, raw_y, raw_z, output ready);
endinterface

interface chc_result_if;
	import chc_pkg::*;
	logic  valid;
	logic  ready;
	corr_t corr_x;
	corr_t corr_y;
	corr_t corr_z;
	head_t heading;
	logic  heading_held;
	logic  cal_done;
	modport source (output valid, corr_x, corr_y, corr_z, heading, heading_held, cal_done,
		input ready);
	modport sink   (input valid, corr_x, corr_y, corr_z, heading, heading_held, cal_done,
		output ready);
endinterface

FILE: src/chc_cal.sv
// Hard-iron tracker: per-axis max/min, calibration counter and axis offsets.
// Depends on chc_pkg.
module chc_cal (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       upd,
	input  chc_pkg::axis_vec_t         raw,
	input  logic [chc_pkg::CAL_W-1:0]  cal_count,
	output chc_pkg::axis_vec_t         offset,
	output logic                       done
);
	import chc_pkg::*;

	axis_vec_t              max_q, min_q, off_q;
	axis_vec_t              nmax, nmin, noff;
	logic [CAL_W-1:0]       cnt_q, cnt_next;
	logic signed [SAMPLE_BITS:0] sum [NUM_AXES];
	logic signed [SAMPLE_BITS:0] adj [NUM_AXES];

	assign cnt_next = cnt_q + CAL_W'(1);
	assign done     = upd && (cnt_next >= cal_count);
	assign offset   = off_q;

	// fold the sample in, then halve toward zero
	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			nmax[k] = ($signed(raw[k]) > $signed(max_q[k])) ? raw[k] : max_q[k];
			nmin[k] = ($signed(raw[k]) < $signed(min_q[k])) ? raw[k] : min_q[k];
			sum[k]  = $signed({nmax[k][SAMPLE_BITS-1], nmax[k]})
				+ $signed({nmin[k][SAMPLE_BITS-1], nmin[k]});
			adj[k]  = sum[k] + $signed({{SAMPLE_BITS{1'b0}}, sum[k][SAMPLE_BITS]});
			noff[k] = adj[k][SAMPLE_BITS:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
			min_q <= '0;
			off_q <= '0;
			cnt_q <= '0;
		end else if (upd) begin
			if (done) begin
				off_q <= noff;
				max_q <= '0;
				min_q <= '0;
				cnt_q <= '0;
			end else begin
				max_q <= nmax;
				min_q <= nmin;
				cnt_q <= cnt_next;
			end
		end
	end

endmodule

FILE: src/chc_cordic.sv
// Iterative CORDIC vectoring unit: one shift-add rotation per cycle, then heading rounding.
// Depends on chc_pkg for widths and the arctangent table.
module chc_cordic (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  chc_pkg::corr_t x,
	input  chc_pkg::corr_t y,
	output logic           done,
	output chc_pkg::head_t heading
);
	import chc_pkg::*;

	localparam logic signed [ZW-1:0] NINETY_Q = ZW'(90) <<< ACC_FRAC;
	localparam logic signed [ZW-1:0] HALF_Q   = ZW'(1) <<< (RND_SH - 1);
	localparam logic signed [ZW-1:0] C_NEG    = NINETY_Q + HALF_Q;
	localparam logic signed [ZW-1:0] C_POS    = HALF_Q - NINETY_Q;

	logic signed [CW-1:0] cx_q, cy_q, dx, dy;
	logic signed [ZW-1:0] z_q, step, hs, hs_sh;
	logic [ITER_W-1:0]    i_q;
	logic                 run_q, fin_q, xneg_q;
	logic [CORR_W-1:0]    ax;

	assign ax   = x[CORR_W-1] ? CORR_W'(-x) : x;
	assign dx   = cy_q >>> i_q;
	assign dy   = cx_q >>> i_q;
	assign step = $signed({{(ZW-32){1'b0}}, ATAN_TAB[TAB_IW'(i_q)]});

	// fold the quadrant in and round half up to the output grid
	assign hs      = xneg_q ? (C_NEG - z_q) : (z_q + C_POS);
	assign hs_sh   = hs >>> RND_SH;
	assign heading = hs_sh[HEAD_W-1:0];
	assign done    = fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			i_q   <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				i_q <= i_q + ITER_W'(1);
				if (i_q == ITER_W'(ITERS - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cx_q   <= $signed({{(CW-CORR_W-ACC_FRAC){1'b0}}, ax, {ACC_FRAC{1'b0}}});
			cy_q   <= $signed({{(CW-CORR_W-ACC_FRAC){y[CORR_W-1]}}, y, {ACC_FRAC{1'b0}}});
			z_q    <= '0;
			xneg_q <= x[CORR_W-1];
		end else if (run_q) begin
			if (cy_q > 0) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				z_q  <= z_q + step;
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				z_q  <= z_q - step;
			end
		end
	end

endmodule

FILE: src/compass_calibrate_heading_unit.sv
// A calibration word, or a measure word with zero corrected x, goes from S_PREP straight to
// S_DONE; any other measure word first waits in S_WAIT through the 16 CORDIC rotations.
// A new sample word is taken only in S_IDLE: words pass the CORDIC shift-add unit one at a time.
// A finished result waits in the output register while the next sample word is taken.
// arst_n clears offsets, trackers, counter, last heading, sequencer and output valid;
// cal_count returns to 500.
module compass_calibrate_heading_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	chc_sample_if.sink                  sample,
	chc_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [chc_pkg::APB_AW-1:0]  paddr,
	input  logic [chc_pkg::APB_DW-1:0]  pwdata,
	output logic [chc_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import chc_pkg::*;

	// Sequencer: take a word, settle its kind, wait on the CORDIC, hand off the result
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PREP = 4'b0010,
		S_WAIT = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t           state_q;
	logic [CAL_W-1:0] cal_count_q;
	logic             cfg_wr;

	logic      op_q;
	axis_vec_t raw_q;
	corr_t     corr_x_q, corr_y_q, corr_z_q;
	head_t     last_heading_q;
	logic      held_q, done_q;

	// Output register
	logic  out_valid_q;
	corr_t out_x_q, out_y_q, out_z_q;
	head_t out_head_q;
	logic  out_held_q, out_done_q;

	axis_vec_t offset;
	logic      cal_upd, cal_done_w;
	logic      cordic_start, cordic_done;
	head_t     cordic_heading;
	logic      in_take, out_load;
	logic      x_zero;

	// APB register: always ready, write on the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_CAL_COUNT);
	assign prdata = (paddr == ADDR_CAL_COUNT) ? APB_DW'(cal_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_count_q <= CAL_COUNT_RST;
		end else if (cfg_wr) begin
			cal_count_q <= pwdata[CAL_W-1:0];
		end
	end

	assign sample.ready = (state_q == S_IDLE);
	assign in_take      = sample.valid && sample.ready;
	assign out_load     = (state_q == S_DONE) && (!out_valid_q || result.ready);
	assign x_zero       = (corr_x_q == '0);
	assign cal_upd      = (state_q == S_PREP) && (op_q == OP_CAL);
	assign cordic_start = (state_q == S_PREP) && (op_q == OP_MEASURE) && !x_zero;

	chc_cal u_cal (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (cal_upd),
		.raw       (raw_q),
		.cal_count (cal_count_q),
		.offset    (offset),
		.done      (cal_done_w)
	);

	chc_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.x       (corr_x_q),
		.y       (corr_y_q),
		.done    (cordic_done),
		.heading (cordic_heading)
	);

	// Sequencer and last heading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			last_heading_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) state_q <= S_PREP;
				end
				S_PREP: begin
					if (cordic_start) begin
						state_q <= S_WAIT;
					end else begin
						state_q <= S_DONE;
						// straight up or straight down the y axis
						if (op_q == OP_MEASURE) begin
							if (corr_y_q > 0)
								last_heading_q <= '0;
							else if (corr_y_q < 0)
								last_heading_q <= -head_t'(HEAD_MAX);
						end
					end
				end
				S_WAIT: begin
					if (cordic_done) begin
						last_heading_q <= cordic_heading;
						state_q        <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the word and its corrected axes against the offsets now in effect
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q     <= sample.op;
			raw_q    <= {sample.raw_z, sample.raw_y, sample.raw_x};
			corr_x_q <= $signed({sample.raw_x[SAMPLE_BITS-1], sample.raw_x})
				- $signed({offset[0][SAMPLE_BITS-1], offset[0]});
			corr_y_q <= $signed({sample.raw_y[SAMPLE_BITS-1], sample.raw_y})
				- $signed({offset[1][SAMPLE_BITS-1], offset[1]});
			corr_z_q <= $signed({sample.raw_z[SAMPLE_BITS-1], sample.raw_z})
				- $signed({offset[2][SAMPLE_BITS-1], offset[2]});
			held_q   <= 1'b0;
			done_q   <= 1'b0;
		end else if (state_q == S_PREP) begin
			done_q <= cal_done_w;
			held_q <= (op_q == OP_MEASURE) && x_zero && (corr_y_q == '0);
		end
	end

	// Output register: hold until taken, reload when empty or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q    <= corr_x_q;
			out_y_q    <= corr_y_q;
			out_z_q    <= corr_z_q;
			out_head_q <= last_heading_q;
			out_held_q <= held_q;
			out_done_q <= done_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.corr_x       = out_x_q;
	assign result.corr_y       = out_y_q;
	assign result.corr_z       = out_z_q;
	assign result.heading      = out_head_q;
	assign result.heading_held = out_held_q;
	assign result.cal_done     = out_done_q;

endmodule

FILE: src/chc_checker.sv
// Port-level checks of the heading unit, bound onto the top level.
// Depends on chc_pkg and the top level's ports.
module chc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  chc_pkg::head_t              heading,
	input  logic                        heading_held,
	input  logic                        cal_done,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [chc_pkg::APB_AW-1:0]  paddr,
	input  logic [chc_pkg::APB_DW-1:0]  pwdata,
	input  logic [chc_pkg::APB_DW-1:0]  prdata
);
	import chc_pkg::*;

	// one word at a time: a taken word drops ready
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("sample ready stayed high after a word was taken");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(heading_held && cal_done))
		else $error("held heading and calibration done on one result");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(heading) >= -HEAD_MAX && $signed(heading) <= HEAD_MAX))
		else $error("heading out of range");

	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr == ADDR_CAL_COUNT)
		|=> (paddr != ADDR_CAL_COUNT || prdata[CAL_W-1:0] == $past(pwdata[CAL_W-1:0])))
		else $error("cal_count readback differs from the last write");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(heading)))
		else $error("stalled result word changed");

endmodule

bind compass_calibrate_heading_unit chc_checker u_chc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sample.valid),
	.in_ready     (sample.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.heading      (result.heading),
	.heading_held (result.heading_held),
	.cal_done     (result.cal_done),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.pready       (pready),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata)
);
